[rtl/id3_pkg.sv]
package id3_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_SIZE   = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_DATA   = 3'd4
  } id3_phase_t;

  localparam logic [3:0] HDR_LEN   = 4'd10;
  localparam logic [3:0] ID_LEN    = 4'd4;
  localparam logic [3:0] SIZE_LEN  = 4'd4;
  localparam logic [3:0] FLAGS_LEN = 4'd2;

  localparam int unsigned SHIFT_B0 = 21;
  localparam int unsigned SHIFT_B1 = 14;
  localparam int unsigned SHIFT_B2 = 7;

  // frame kinds
  localparam logic [2:0] KIND_TITLE    = 3'd0;
  localparam logic [2:0] KIND_ARTIST   = 3'd1;
  localparam logic [2:0] KIND_ALBUM    = 3'd2;
  localparam logic [2:0] KIND_YEAR     = 3'd3;
  localparam logic [2:0] KIND_GENRE    = 3'd4;
  localparam logic [2:0] KIND_COMPOSER = 3'd5;
  localparam logic [2:0] KIND_COMMENT  = 3'd6;

  // four-character frame ids
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_TRDC = 32'h5452_4443;
  localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
  localparam logic [31:0] ID_TCOM = 32'h5443_4F4D;
  localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

  typedef struct packed {
    id3_phase_t  phase;
    logic [3:0]  field_count;
    logic [31:0] frame_ident;
    logic [29:0] frame_length;
    logic [29:0] bytes_left;
    logic [2:0]  kind;
    logic        known_frame;
    logic        text_ended;
    logic        stopped;
  } id3_state_t;

  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_char;
    logic [2:0] frame_kind;
    logic       frame_last;
    logic       parse_stopped;
  } id3_result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } id3_class_t;

  function automatic id3_class_t classify(input logic [31:0] id);
    id3_class_t c;
    c.hit  = 1'b1;
    c.kind = KIND_TITLE;
    unique case (id)
      ID_TIT2: c.kind = KIND_TITLE;
      ID_TPE1: c.kind = KIND_ARTIST;
      ID_TALB: c.kind = KIND_ALBUM;
      ID_TYER: c.kind = KIND_YEAR;
      ID_TRDC: c.kind = KIND_YEAR;
      ID_TCON: c.kind = KIND_GENRE;
      ID_TCOM: c.kind = KIND_COMPOSER;
      ID_COMM: c.kind = KIND_COMMENT;
      default: c.hit  = 1'b0;
    endcase
    return c;
  endfunction

endpackage

[rtl/id3_if.sv]
interface id3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface id3_out_if;
  logic       valid;
  logic       ready;
  logic       text_valid;
  logic [7:0] text_char;
  logic [2:0] frame_kind;
  logic       frame_last;
  logic       parse_stopped;

  modport source (output valid, output text_valid, output text_char, output frame_kind,
                  output frame_last, output parse_stopped, input ready);
  modport sink   (input valid, input text_valid, input text_char, input frame_kind,
                  input frame_last, input parse_stopped, output ready);
endinterface

[rtl/id3_parse_core.sv]
module id3_parse_core (
  input  id3_pkg::id3_state_t  st_i,
  input  logic [7:0]           byte_i,
  input  logic                 sof_i,
  output id3_pkg::id3_state_t  st_o,
  output id3_pkg::id3_result_t res_o
);

  id3_pkg::id3_state_t base;
  id3_pkg::id3_class_t cls;
  logic [3:0]  cnt_inc;
  logic [29:0] size_part;
  logic        first_byte;
  logic        skip_byte;

  assign cls = id3_pkg::classify(base.frame_ident);

  always_comb begin
    base = st_i;
    if (sof_i) begin
      base = '0;
    end
    st_o       = base;
    res_o      = '0;
    cnt_inc    = base.field_count + 4'd1;
    size_part  = '0;
    first_byte = (base.bytes_left == base.frame_length);
    skip_byte  = first_byte && (base.frame_length > 30'd1);

    if (!base.stopped) begin
      unique case (base.phase)
        id3_pkg::PH_ID: begin
          if ((base.field_count == 4'd0) && (byte_i == 8'd0)) begin
            // padding reached
            st_o.stopped = 1'b1;
          end else begin
            st_o.frame_ident = (base.field_count == 4'd0) ? {24'd0, byte_i}
                                                          : {base.frame_ident[23:0], byte_i};
            if (cnt_inc >= id3_pkg::ID_LEN) begin
              st_o.field_count  = '0;
              st_o.frame_length = '0;
              st_o.phase        = id3_pkg::PH_SIZE;
            end else begin
              st_o.field_count = cnt_inc;
            end
          end
        end
        id3_pkg::PH_SIZE: begin
          unique case (base.field_count[1:0])
            2'd0:    size_part = {22'd0, byte_i} << id3_pkg::SHIFT_B0;
            2'd1:    size_part = {22'd0, byte_i} << id3_pkg::SHIFT_B1;
            2'd2:    size_part = {22'd0, byte_i} << id3_pkg::SHIFT_B2;
            default: size_part = {22'd0, byte_i};
          endcase
          st_o.frame_length = base.frame_length | size_part;
          if (cnt_inc >= id3_pkg::SIZE_LEN) begin
            st_o.field_count = '0;
            st_o.phase       = id3_pkg::PH_FLAGS;
          end else begin
            st_o.field_count = cnt_inc;
          end
        end
        id3_pkg::PH_FLAGS: begin
          if (cnt_inc >= id3_pkg::FLAGS_LEN) begin
            st_o.field_count = '0;
            if (base.frame_length == 30'd0) begin
              st_o.stopped = 1'b1;
            end else begin
              st_o.known_frame = cls.hit;
              st_o.kind        = cls.kind;
              st_o.text_ended  = 1'b0;
              st_o.bytes_left  = base.frame_length;
              st_o.phase       = id3_pkg::PH_DATA;
            end
          end else begin
            st_o.field_count = cnt_inc;
          end
        end
        id3_pkg::PH_DATA: begin
          if (base.known_frame && !base.text_ended && !skip_byte) begin
            if (byte_i == 8'd0) begin
              st_o.text_ended = 1'b1;
            end else begin
              res_o.text_valid = 1'b1;
              res_o.text_char  = byte_i;
              res_o.frame_kind = base.kind;
            end
          end
          if (base.bytes_left <= 30'd1) begin
            res_o.frame_last = 1'b1;
            st_o.bytes_left  = '0;
            st_o.field_count = '0;
            st_o.phase       = id3_pkg::PH_ID;
          end else begin
            st_o.bytes_left = base.bytes_left - 30'd1;
          end
        end
        default: begin
          // tag header skip
          if (cnt_inc >= id3_pkg::HDR_LEN) begin
            st_o.field_count = '0;
            st_o.phase       = id3_pkg::PH_ID;
          end else begin
            st_o.field_count = cnt_inc;
            st_o.phase       = id3_pkg::PH_HEADER;
          end
        end
      endcase
    end

    res_o.parse_stopped = st_o.stopped;
  end

endmodule

[rtl/id3v2_text_frame_parser_unit.sv]
// an accepted byte is held in the input register; its result moves to the result register
// throughput: one byte per cycle while out_ch takes a result every cycle; a stalled result
// keeps one byte in the input register, after which in_ch.ready stays low until out_ch drains
// the per-byte parse is one pass of counter, compare and shift logic between two registers
// reset: synchronous, active low; clears the parser state to the tag header skip phase,
// empties both the input and the result register
module id3v2_text_frame_parser_unit (
  input logic    clk,
  input logic    rst_n,
  id3_in_if.sink    in_ch,
  id3_out_if.source out_ch
);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_sof_r;

  // result register
  logic                 out_vld_r;
  id3_pkg::id3_result_t out_res_r;

  // parser state
  id3_pkg::id3_state_t st_r;
  id3_pkg::id3_state_t st_nxt;
  id3_pkg::id3_result_t res_nxt;

  logic advance;   // input register moves into the result register
  logic take_in;

  // result register is free when empty or its transaction completes this cycle
  assign advance  = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign take_in  = in_ch.valid && in_ch.ready;

  id3_parse_core u_core (
    .st_i   (st_r),
    .byte_i (in_byte_r),
    .sof_i  (in_sof_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (take_in) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;   // state moves once per byte
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_byte_r <= in_ch.file_byte;
      in_sof_r  <= in_ch.start_of_file;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.text_valid    = out_res_r.text_valid;
  assign out_ch.text_char     = out_res_r.text_char;
  assign out_ch.frame_kind    = out_res_r.frame_kind;
  assign out_ch.frame_last    = out_res_r.frame_last;
  assign out_ch.parse_stopped = out_res_r.parse_stopped;

  // a waiting byte is not lost while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_ch.ready |=> in_vld_r && $stable(in_byte_r))
    else $error("input register dropped a byte under stall");

  // stop is sticky until a start of file byte is processed
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stopped && !(advance && in_sof_r) |=> st_r.stopped)
    else $error("parser left the stopped state without start of file");

  // text is never emitted on a stopped result
  a_no_text_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.text_valid |-> !out_res_r.parse_stopped)
    else $error("text byte emitted after parsing stopped");

  // state only changes when a byte is processed
  a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("parser state changed without a byte");

endmodule

[tb/tb_id3v2_text_frame_parser_unit.sv]
`timescale 1ns / 100ps

module tb_id3v2_text_frame_parser_unit;

  // tag layout
  localparam int HEADER_BYTES = 10;
  localparam int ID_BYTES     = 4;
  localparam int SIZE_BYTES   = 4;
  localparam int FLAG_BYTES   = 2;
  localparam int SIZE_STEP    = 7;

  // frame ids, spelled out as ascii
  localparam logic [31:0] TAG_TIT2 = "TIT2";
  localparam logic [31:0] TAG_TPE1 = "TPE1";
  localparam logic [31:0] TAG_TALB = "TALB";
  localparam logic [31:0] TAG_TYER = "TYER";
  localparam logic [31:0] TAG_TRDC = "TRDC";
  localparam logic [31:0] TAG_TCON = "TCON";
  localparam logic [31:0] TAG_TCOM = "TCOM";
  localparam logic [31:0] TAG_COMM = "COMM";
  localparam logic [31:0] TAG_ODD  = "XYZ1";
  localparam logic [31:0] KNOWN_TAGS [8] = '{TAG_TIT2, TAG_TPE1, TAG_TALB, TAG_TYER,
                                             TAG_TRDC, TAG_TCON, TAG_TCOM, TAG_COMM};

  // run length and limits
  localparam int RANDOM_BYTES   = 1450;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 4;

  // how a generated frame left the parser
  typedef enum int {FRAME_DONE, FRAME_CUT, FRAME_STOP} frame_outcome_t;

  // tracks the parser state per byte and keeps the text results still owed
  class frame_text_checker;
    id3_pkg::id3_phase_t  phase;
    logic [3:0]           field_count;
    logic [31:0]          frame_ident;
    logic [29:0]          frame_length;
    logic [29:0]          bytes_left;
    logic [2:0]           kind;
    bit                   known_frame;
    bit                   text_ended;
    bit                   stopped;
    id3_pkg::id3_result_t text_results_due[$];
    int                   mismatches;
    int                   results_seen;

    function new();
      restart();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void restart();
      phase        = id3_pkg::PH_HEADER;
      field_count  = '0;
      frame_ident  = '0;
      frame_length = '0;
      bytes_left   = '0;
      kind         = id3_pkg::KIND_TITLE;
      known_frame  = 1'b0;
      text_ended   = 1'b0;
      stopped      = 1'b0;
    endfunction

    function bit lookup_kind(input logic [31:0] id, output logic [2:0] k);
      k = id3_pkg::KIND_TITLE;
      case (id)
        TAG_TIT2: k = id3_pkg::KIND_TITLE;
        TAG_TPE1: k = id3_pkg::KIND_ARTIST;
        TAG_TALB: k = id3_pkg::KIND_ALBUM;
        TAG_TYER: k = id3_pkg::KIND_YEAR;
        TAG_TRDC: k = id3_pkg::KIND_YEAR;
        TAG_TCON: k = id3_pkg::KIND_GENRE;
        TAG_TCOM: k = id3_pkg::KIND_COMPOSER;
        TAG_COMM: k = id3_pkg::KIND_COMMENT;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function id3_pkg::id3_result_t parse_byte(input logic [7:0] b, input logic sof);
      id3_pkg::id3_result_t r;
      logic [29:0]          widened;
      bit                   lead;
      r = '0;
      if (sof) restart();
      if (!stopped) begin
        case (phase)
          id3_pkg::PH_ID: begin
            // zero first id byte is padding
            if (field_count == 0 && b == 8'h00) begin
              stopped = 1'b1;
            end else begin
              frame_ident = {frame_ident[23:0], b};
              field_count++;
              if (field_count == ID_BYTES) begin
                field_count  = '0;
                frame_length = '0;
                phase        = id3_pkg::PH_SIZE;
              end
            end
          end
          id3_pkg::PH_SIZE: begin
            // all eight bits taken, overlaps or-ed together
            widened = {22'b0, b};
            frame_length |= widened << (SIZE_STEP * (3 - int'(field_count)));
            field_count++;
            if (field_count == SIZE_BYTES) begin
              field_count = '0;
              phase       = id3_pkg::PH_FLAGS;
            end
          end
          id3_pkg::PH_FLAGS: begin
            field_count++;
            if (field_count == FLAG_BYTES) begin
              field_count = '0;
              if (frame_length == 0) begin
                stopped = 1'b1;
              end else begin
                known_frame = lookup_kind(frame_ident, kind);
                text_ended  = 1'b0;
                bytes_left  = frame_length;
                phase       = id3_pkg::PH_DATA;
              end
            end
          end
          id3_pkg::PH_DATA: begin
            lead = (bytes_left == frame_length) && (frame_length > 1);
            if (known_frame && !text_ended && !lead) begin
              if (b == 8'h00) begin
                text_ended = 1'b1;
              end else begin
                r.text_valid = 1'b1;
                r.text_char  = b;
                r.frame_kind = kind;
              end
            end
            if (bytes_left <= 1) begin
              r.frame_last = 1'b1;
              bytes_left   = '0;
              field_count  = '0;
              phase        = id3_pkg::PH_ID;
            end else begin
              bytes_left--;
            end
          end
          default: begin
            field_count++;
            if (field_count >= HEADER_BYTES) begin
              field_count = '0;
              phase       = id3_pkg::PH_ID;
            end
          end
        endcase
      end
      r.parse_stopped = stopped;
      return r;
    endfunction

    function void note_byte(input logic [7:0] b, input logic sof);
      text_results_due.push_back(parse_byte(b, sof));
    endfunction

    function int pending();
      return text_results_due.size();
    endfunction

    task report(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(input logic tv, input logic [7:0] tc, input logic [2:0] fk,
                      input logic fl, input logic ps);
      id3_pkg::id3_result_t want;
      results_seen++;
      if (text_results_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed", results_seen));
        return;
      end
      want = text_results_due.pop_front();
      if (tv !== want.text_valid || tc !== want.text_char || fk !== want.frame_kind ||
          fl !== want.frame_last || ps !== want.parse_stopped) begin
        report($sformatf("result %0d got v%b c%h k%0d l%b s%b, want v%b c%h k%0d l%b s%b",
                         results_seen, tv, tc, fk, fl, ps, want.text_valid, want.text_char,
                         want.frame_kind, want.frame_last, want.parse_stopped));
      end
    endtask

    task finish_check();
      if (text_results_due.size() != 0)
        report($sformatf("%0d results never arrived", text_results_due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  id3_in_if  in_ch ();
  id3_out_if out_ch ();

  id3v2_text_frame_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  frame_text_checker parser_check = new();

  int bytes_taken = 0;   // input transactions seen by the monitor
  int bytes_sent  = 0;   // input transactions completed by the sender
  int burst_left  = 0;
  int idle_cycles = 0;

  // monitor: both channels sampled at the edge, before any nba updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parser_check.note_byte(in_ch.file_byte, in_ch.start_of_file);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_ch.valid && out_ch.ready)
        parser_check.check_result(out_ch.text_valid, out_ch.text_char, out_ch.frame_kind,
                                  out_ch.frame_last, out_ch.parse_stopped);
    end
  end

  // watchdog: any transaction on either side resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stretches of a ready pattern repeated from an eight-bit mask, some of them
  // all ready, plus one long hold-off so the input side backs up
  initial begin : result_sink
    logic [7:0] stall_pattern;
    int         stretch;
    bit         held_off;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && bytes_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stretch       = $urandom_range(4, 48);
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        for (int k = 0; k < stretch; k++) begin
          out_ch.ready <= stall_pattern[k % 8];
          @(posedge clk);
        end
      end
    end
  end

  // one byte per call; the sender runs in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.file_byte     <= b;
    in_ch.start_of_file <= sof;
    // transaction completes on the first edge with ready high
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // sender holds off until every owed result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (parser_check.pending() != 0) @(posedge clk);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic add_header(input bit mark);
    for (int i = 0; i < HEADER_BYTES; i++) send_byte(8'($urandom), mark && i == 0);
  endtask

  // id, size field, two flag bytes, then the payload; a payload longer than
  // cap is cut short and the caller restarts the file
  task automatic add_frame(input logic [31:0] id, input logic [31:0] size_field,
                           input int cap, input bit wide, input int zero_at,
                           output frame_outcome_t outcome);
    int unsigned len;
    int unsigned body;
    for (int i = ID_BYTES - 1; i >= 0; i--) send_byte(id[8*i +: 8], 1'b0);
    for (int i = SIZE_BYTES - 1; i >= 0; i--) send_byte(size_field[8*i +: 8], 1'b0);
    send_noise(FLAG_BYTES);
    len = (int'(size_field[31:24]) << 21) | (int'(size_field[23:16]) << 14) |
          (int'(size_field[15:8]) << 7) | int'(size_field[7:0]);
    if (len == 0) begin
      outcome = FRAME_STOP;
      return;
    end
    body = (len > cap) ? cap : len;
    for (int i = 0; i < body; i++)
      send_byte((i == zero_at) ? 8'h00 : wide ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(32, 126)), 1'b0);
    outcome = (len > cap) ? FRAME_CUT : FRAME_DONE;
  endtask

  // a mostly well-formed tag with random content; the file may end in padding,
  // a partial frame or nothing, and the next header's start mark cuts it off
  task automatic random_file();
    int             frames;
    int             pick;
    int             cap;
    int             zero_at;
    logic [31:0]    id;
    logic [31:0]    size_field;
    frame_outcome_t outcome;
    add_header($urandom_range(0, 19) != 0);
    frames = $urandom_range(0, 6);
    for (int f = 0; f < frames; f++) begin
      pick = $urandom_range(0, 99);
      id = (pick < 75) ? KNOWN_TAGS[$urandom_range(0, 7)]
                       : {8'($urandom_range(1, 255)), 24'($urandom)};
      pick = $urandom_range(0, 99);
      cap  = 700;
      if (pick < 65) begin
        size_field = $urandom_range(1, 24);
      end else if (pick < 75) begin
        size_field = $urandom_range(0, 255);
      end else if (pick < 82) begin
        // low size bytes overlap once shifted
        size_field = {16'h0, 8'($urandom_range(1, 3)), 8'($urandom)};
      end else if (pick < 90) begin
        size_field = '0;
      end else begin
        size_field = $urandom;
        cap        = $urandom_range(0, 24);
      end
      zero_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : -1;
      add_frame(id, size_field, cap, $urandom_range(0, 2) == 0, zero_at, outcome);
      if (outcome == FRAME_CUT) return;
      if (outcome == FRAME_STOP) begin
        send_noise($urandom_range(0, 4));
        return;
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(8'h00, 1'b0);
      send_noise($urandom_range(0, 5));
    end else if (pick < 55) begin
      send_noise($urandom_range(1, 9));
    end
  endtask

  initial begin : stimulus
    frame_outcome_t outcome;
    int             random_start;
    int             file_no;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.file_byte     <= 8'h00;
    in_ch.start_of_file <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // first file right after reset carries no start mark
    add_header(1'b0);
    add_frame(TAG_TIT2, 32'd6, 700, 1'b0, -1, outcome);
    // size one: the lone byte is text, then a lone zero byte
    add_frame(TAG_TPE1, 32'd1, 700, 1'b0, -1, outcome);
    add_frame(TAG_TALB, 32'd1, 700, 1'b0, 0, outcome);
    // skipped leading byte is zero and must not end the text
    add_frame(TAG_TYER, 32'd4, 700, 1'b0, 0, outcome);
    // zero in mid-text swallows the rest of the payload
    add_frame(TAG_TRDC, 32'd6, 700, 1'b0, 3, outcome);
    add_frame(TAG_TCON, 32'd3, 700, 1'b1, -1, outcome);
    add_frame(TAG_TCOM, 32'd3, 700, 1'b1, -1, outcome);
    add_frame(TAG_COMM, 32'd5, 700, 1'b1, -1, outcome);
    // unknown id: silent payload, last flag still given
    add_frame(TAG_ODD, 32'd3, 700, 1'b1, -1, outcome);
    // padding stops the parse; later bytes are ignored
    send_byte(8'h00, 1'b0);
    send_noise(3);

    // all size bits set, then a restart in the middle of the payload
    add_header(1'b1);
    add_frame(TAG_TIT2, 32'hFFFF_FFFF, 6, 1'b1, -1, outcome);
    // restart in the middle of a size field
    add_header(1'b1);
    for (int i = ID_BYTES - 1; i >= 0; i--) send_byte(TAG_TCOM[8*i +: 8], 1'b0);
    send_noise(2);
    // zero size stops on the second flag byte
    add_header(1'b1);
    add_frame(TAG_COMM, 32'd0, 700, 1'b0, -1, outcome);
    send_noise(3);
    // restart in the middle of a header
    send_byte(8'($urandom), 1'b1);
    send_noise(4);
    add_header(1'b1);
    send_noise(4);

    random_start = bytes_sent;
    file_no      = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      random_file();
      file_no++;
      // now and then let the block run empty before the next file
      if (file_no % 30 == 10) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    parser_check.finish_check();
    if (parser_check.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/id3_pkg.sv
rtl/id3_if.sv
rtl/id3_parse_core.sv
rtl/id3v2_text_frame_parser_unit.sv
tb/tb_id3v2_text_frame_parser_unit.sv
